[hw/rtl/sv39_page_table_walker_macros.svh]
// ----------------------------------------------------------------------------
// Sv39 page table walker: assertion macros
// Shared assertion forms for the walker's modules. Each expects clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SV39PTW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SV39PTW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sv39ptw_pkg.sv]
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Item types, status codes and the command and status groups between the
// walk controller and the table datapath.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

	localparam int VA_W     = 39;
	localparam int PA_W     = 56;
	localparam int PERM_W   = 8;
	localparam int STATUS_W = 3;
	localparam int PTE_W    = 54;
	localparam int PPN_LSB  = 10;
	localparam int PPN_W    = PTE_W - PPN_LSB;
	localparam int OFF_W    = 12;
	localparam int VPN_W    = 9;
	localparam int FREE_W   = 9;
	localparam int LVL_W    = 2;

	localparam logic [LVL_W-1:0]  TOP_LEVEL = 2'd2;
	localparam logic [PERM_W-1:0] PERM_V    = 8'h01;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_MAP    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd4;

	typedef struct packed {
		logic              action;
		logic [VA_W-1:0]   virt_addr;
		logic [PA_W-1:0]   phys_addr;
		logic [PERM_W-1:0] perm_bits;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PTE_W-1:0]    leaf_entry;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic                load;
		logic                rd;
		logic                follow;
		logic                alloc;
		logic                clr;
		logic                wr_leaf;
		logic                fin;
		logic [LVL_W-1:0]    level;
		logic [VPN_W-1:0]    clr_idx;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_map;
		logic misaligned;
		logic tbl_ok;
		logic leaf_valid;
		logic page_left;
	} st_t;

endpackage

[hw/rtl/sv39ptw_ctrl.sv]
// ----------------------------------------------------------------------------
// Sv39 page table walker: walk controller
// Sequences root clearing, the three-level walk, page allocation with its
// clearing sweep, and the final result.
// ----------------------------------------------------------------------------
`include "sv39_page_table_walker_macros.svh"

module sv39ptw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sv39ptw_pkg::st_t   st,
	output sv39ptw_pkg::cmd_t  cmd
);
	import sv39ptw_pkg::*;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;
	localparam logic [2:0] S_ZERO  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic [VPN_W-1:0] clr_q, clr_d;
	logic [2:0]       wr_vec;

	always_comb begin
		cmd         = '0;
		cmd.level   = lvl_q;
		cmd.clr_idx = clr_q;
		state_d     = state_q;
		lvl_d       = lvl_q;
		clr_d       = clr_q;
		case (state_q)
			S_INIT: begin
				cmd.clr = 1'b1;
				clr_d   = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					lvl_d    = TOP_LEVEL;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.is_map && st.misaligned) begin
					cmd.fin    = 1'b1;
					cmd.status = ST_MISALIGNED;
					state_d    = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (lvl_q != '0) begin
					if (st.tbl_ok) begin
						cmd.follow = 1'b1;
						lvl_d      = lvl_q - 1'b1;
						state_d    = S_READ;
					end else if (!st.is_map) begin
						cmd.fin    = 1'b1;
						cmd.status = ST_NOT_MAPPED;
						state_d    = S_IDLE;
					end else if (!st.page_left) begin
						cmd.fin    = 1'b1;
						cmd.status = ST_NO_PAGE;
						state_d    = S_IDLE;
					end else begin
						cmd.alloc = 1'b1;
						clr_d     = '0;
						state_d   = S_ZERO;
					end
				end else begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
					if (!st.is_map) begin
						cmd.status = ST_OK;
					end else if (st.leaf_valid) begin
						cmd.status = ST_MAPPED;
					end else begin
						cmd.wr_leaf = 1'b1;
						cmd.status  = ST_OK;
					end
				end
			end
			S_ZERO: begin
				cmd.clr = 1'b1;
				clr_d   = clr_q + 1'b1;
				if (&clr_q) begin
					lvl_d   = lvl_q - 1'b1;
					state_d = S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			lvl_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			clr_q   <= clr_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign wr_vec = {cmd.alloc, cmd.clr, cmd.wr_leaf};

	`SV39PTW_ASSERT_IMP(a_single_write, 1'b1, $onehot0(wr_vec), "more than one table write at once")
	`SV39PTW_ASSERT_NXT(a_fin_idle, cmd.fin, state_q == S_IDLE, "walker not idle after result")
	`SV39PTW_ASSERT_NXT(a_alloc_sweep, cmd.alloc, (state_q == S_ZERO) && (clr_q == '0), "allocation not followed by a clearing sweep")

endmodule

[hw/rtl/sv39ptw_dp.sv]
// ----------------------------------------------------------------------------
// Sv39 page table walker: table datapath
// Holds the item, the table store, the current table page, the free page
// counter and the result register.
// ----------------------------------------------------------------------------
`include "sv39_page_table_walker_macros.svh"

module sv39ptw_dp #(
	parameter int TABLE_PAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sv39ptw_pkg::req_t  req,
	input  sv39ptw_pkg::cmd_t  cmd,
	output sv39ptw_pkg::st_t   st,
	output logic               done,
	output sv39ptw_pkg::rsp_t  rsp
);
	import sv39ptw_pkg::*;

	localparam int PAGE_W = $clog2(TABLE_PAGES);
	localparam int ADDR_W = PAGE_W + VPN_W;
	localparam int DEPTH  = TABLE_PAGES * (2 ** VPN_W);

	logic [PTE_W-1:0]  mem [DEPTH];

	req_t              req_q;
	logic [PAGE_W-1:0] page_q;
	logic [FREE_W-1:0] next_free_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PTE_W-1:0]  rdata_q;
	rsp_t              rsp_q;
	logic              done_q;

	logic [VPN_W-1:0]  slice;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [PTE_W-1:0]  wdata;
	logic              we;
	logic [PTE_W-1:0]  leaf_new;
	logic [PTE_W-1:0]  ptr_new;

	always_comb begin
		case (cmd.level)
			2'd0:    slice = req_q.virt_addr[OFF_W +: VPN_W];
			2'd1:    slice = req_q.virt_addr[OFF_W + VPN_W +: VPN_W];
			2'd2:    slice = req_q.virt_addr[OFF_W + 2 * VPN_W +: VPN_W];
			default: slice = '0;
		endcase
	end

	assign raddr    = {page_q, slice};
	assign leaf_new = {req_q.phys_addr[PA_W-1:OFF_W], 2'b00, req_q.perm_bits | PERM_V};
	assign ptr_new  = {PPN_W'(next_free_q), (PPN_LSB - 1)'(0), 1'b1};

	always_comb begin
		we    = cmd.alloc | cmd.clr | cmd.wr_leaf;
		waddr = addr_q;
		wdata = leaf_new;
		if (cmd.clr) begin
			waddr = {page_q, cmd.clr_idx};
			wdata = '0;
		end else if (cmd.alloc) begin
			wdata = ptr_new;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
			addr_q  <= raddr;
		end
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.fin) begin
			rsp_q.status <= cmd.status;
			if (cmd.status != ST_OK) begin
				rsp_q.leaf_entry <= '0;
			end else if (req_q.action == ACT_MAP) begin
				rsp_q.leaf_entry <= leaf_new;
			end else begin
				rsp_q.leaf_entry <= rdata_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q      <= '0;
			next_free_q <= FREE_W'(1);
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.load) begin
				page_q <= '0;
			end else if (cmd.follow) begin
				page_q <= rdata_q[PPN_LSB +: PAGE_W];
			end else if (cmd.alloc) begin
				page_q      <= next_free_q[PAGE_W-1:0];
				next_free_q <= next_free_q + 1'b1;
			end
		end
	end

	assign st.is_map     = (req_q.action == ACT_MAP);
	assign st.misaligned = (req_q.virt_addr[OFF_W-1:0] != '0) ||
	                       (req_q.phys_addr[OFF_W-1:0] != '0);
	assign st.leaf_valid = rdata_q[0];
	assign st.tbl_ok     = rdata_q[0] &&
	                       (rdata_q[PTE_W-1:PPN_LSB] < PPN_W'(TABLE_PAGES));
	assign st.page_left  = (next_free_q < FREE_W'(TABLE_PAGES));

	assign done = done_q;
	assign rsp  = rsp_q;

	`SV39PTW_ASSERT_IMP(a_fail_zero_leaf, done_q && (rsp_q.status != ST_OK), rsp_q.leaf_entry == '0, "failed result carries a leaf entry")
	`SV39PTW_ASSERT_NXT(a_alloc_bump, cmd.alloc, next_free_q == ($past(next_free_q) + 1'b1), "free page counter did not advance")
	`SV39PTW_ASSERT_IMP(a_free_bound, 1'b1, next_free_q <= FREE_W'(TABLE_PAGES), "free page counter beyond table pages")

endmodule

[hw/rtl/sv39_page_table_walker.sv]
// ----------------------------------------------------------------------------
// Sv39 page table walker
// Three-level Sv39 page table kept in an internal store, with lookup of a
// leaf entry and mapping of a single page.
// ----------------------------------------------------------------------------
// Raise start with an item on req while busy is low; the item is taken at
// that edge. One item is worked on at a time: a lookup, or a map that passes
// the alignment check, walks levels 2, 1 and 0 through a single-port table
// store with a registered read, each level passing through a read state and
// an evaluate state, and the result strobe (done, with rsp) is registered
// from the final decision. A walk that ends at an invalid entry of level 2
// or level 1 (a lookup that finds a hole, or a map that finds no table page
// left) answers early, as does a map rejected for misalignment, before any
// table read. Every table page that a map takes from the free counter is
// swept to zero one entry a cycle. After reset the block clears the root
// page the same way and holds busy high until that sweep ends, before the
// first item. done is high for exactly one cycle and the receiver cannot
// stall it, so capture rsp in that cycle; busy is already low then, and a
// new item can be taken in the same cycle. Pages taken by a map that then
// runs out of table pages stay allocated.
// ----------------------------------------------------------------------------
module sv39_page_table_walker #(
	parameter int TABLE_PAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sv39ptw_pkg::req_t  req,
	output logic               done,
	output sv39ptw_pkg::rsp_t  rsp
);
	import sv39ptw_pkg::*;

	cmd_t cmd;
	st_t  st;

	// Walk sequencing: root clear, per-level read and decide, page sweep.
	sv39ptw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// Table store, current page, free counter and result register.
	sv39ptw_dp #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
